>>> rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// shared widths, codes and state type of the canonical huffman decoder
// ----------------------------------------------------------------------------
package chd_pkg;

    // item field widths
    localparam int KIND_W      = 2;
    localparam int SYM_FIELD_W = 9;
    localparam int LEN_FIELD_W = 6;
    localparam int WIN_W       = 32;

    // default sizing of the code book
    localparam int NUM_SYMBOLS_DEF  = 256 + 1;
    localparam int MAX_CODE_LEN_DEF = 32;

    // end symbol register after reset
    localparam logic [SYM_FIELD_W-1:0] END_SYMBOL_RST = 9'd256;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_BUILD  = 2'd1,
        KIND_DECODE = 2'd2
    } t_kind;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BSCAN,
        S_DSTEP,
        S_DREAD,
        S_DDONE
    } t_state;

endpackage

>>> rtl/chd_if.sv
// ----------------------------------------------------------------------------
// chd_if
// valid/ready channels carrying input items and result items
// ----------------------------------------------------------------------------
interface chd_in_if;
    logic                              valid;
    logic                              ready;
    logic [chd_pkg::KIND_W-1:0]        kind;
    logic [chd_pkg::SYM_FIELD_W-1:0]   symbol_index;
    logic [chd_pkg::LEN_FIELD_W-1:0]   code_length;
    logic [chd_pkg::WIN_W-1:0]         bit_window;

    modport source (output valid, kind, symbol_index, code_length, bit_window,
                    input  ready);
    modport sink   (input  valid, kind, symbol_index, code_length, bit_window,
                    output ready);
endinterface

interface chd_out_if;
    logic                              valid;
    logic                              ready;
    logic [chd_pkg::SYM_FIELD_W-1:0]   decoded_symbol;
    logic [chd_pkg::LEN_FIELD_W-1:0]   bits_used;
    logic                              is_end;
    logic                              no_match;

    modport source (output valid, decoded_symbol, bits_used, is_end, no_match,
                    input  ready);
    modport sink   (input  valid, decoded_symbol, bits_used, is_end, no_match,
                    output ready);
endinterface

>>> rtl/canonical_huffman_decoder.sv
// ----------------------------------------------------------------------------
// canonical_huffman_decoder
// canonical huffman code book builder and single-symbol decoder
// ----------------------------------------------------------------------------
// usage:
//   i_in carries items of three kinds. a load item writes one symbol's code
//   length (indexes at or above NUM_SYMBOLS are dropped). a build item turns
//   the stored lengths into canonical codes. a decode item presents a
//   left-aligned 32-bit window and gets one result item on o_out.
//   kind 3, load and build items give no result.
//   i_cfg_wr_en / i_cfg_wr_data write the end symbol register (reset 256).
// timing:
//   after reset a clearing pass zeroes the length memory; i_in.ready stays low
//   meanwhile. build: one pass over the length memory per code length, one
//   memory read per cycle. decode: one compare step per code length,
//   shortest first, until a hit or a miss at MAX_CODE_LEN.
//   one item is in work at a time; ready is high only when the sequencer idles.
// stall:
//   the result sits in an output register; while it is not taken the block
//   still accepts and runs further items, and a decode that finishes waits
//   in its last state until the output register frees up.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder #(
    parameter int NUM_SYMBOLS  = chd_pkg::NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [chd_pkg::SYM_FIELD_W-1:0]  i_cfg_wr_data,
    chd_in_if.sink                           i_in,
    chd_out_if.source                        o_out
);

    // symbol address, symbol count (0..NUM_SYMBOLS) and code length widths
    localparam int SYM_W  = $clog2(NUM_SYMBOLS);
    localparam int CNT_W  = $clog2(NUM_SYMBOLS + 1);
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int CODE_W = MAX_CODE_LEN + 1;
    localparam int CMP_W  = (MAX_CODE_LEN > CNT_W) ? MAX_CODE_LEN : CNT_W;

    // sequencer
    chd_pkg::t_state r_state, n_state;

    // configuration
    logic [chd_pkg::SYM_FIELD_W-1:0] r_end_symbol;

    // memories
    logic [chd_pkg::LEN_FIELD_W-1:0] mem_len    [NUM_SYMBOLS];
    logic [SYM_W-1:0]                mem_sorted [NUM_SYMBOLS];

    // per-length decode tables (one entry per code length)
    logic [MAX_CODE_LEN-1:0] r_first_code [1:MAX_CODE_LEN];
    logic [CNT_W-1:0]        r_count      [1:MAX_CODE_LEN];
    logic [CNT_W-1:0]        r_first_idx  [1:MAX_CODE_LEN];

    // shared working registers
    logic [LEN_W-1:0]        r_len, n_len;
    logic [CNT_W-1:0]        r_s, n_s;
    logic                    r_rd_vld, n_rd_vld;
    logic [SYM_W-1:0]        r_rd_sym, n_rd_sym;
    logic [chd_pkg::LEN_FIELD_W-1:0] r_rd_len;
    logic [CODE_W-1:0]       r_c, n_c;
    logic                    r_big, n_big;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [MAX_CODE_LEN-1:0] r_first, n_first;
    logic [CNT_W-1:0]        r_pos, n_pos;
    logic [MAX_CODE_LEN-1:0] r_v, n_v;
    logic [chd_pkg::WIN_W-1:0] r_win, n_win;
    logic [SYM_W-1:0]        r_idx, n_idx;
    logic [SYM_W-1:0]        r_sym_rd;
    logic                    r_miss, n_miss;

    // output register
    logic                                r_out_valid, n_out_valid;
    logic [chd_pkg::SYM_FIELD_W-1:0]     r_out_sym, n_out_sym;
    logic [chd_pkg::LEN_FIELD_W-1:0]     r_out_bits, n_out_bits;
    logic                                r_out_end, n_out_end;
    logic                                r_out_miss, n_out_miss;

    // memory and table port controls
    logic                             len_we;
    logic [SYM_W-1:0]                 len_waddr;
    logic [chd_pkg::LEN_FIELD_W-1:0]  len_wdata;
    logic                             len_re;
    logic [SYM_W-1:0]                 len_raddr;
    logic                             srt_we;
    logic [SYM_W-1:0]                 srt_waddr;
    logic [SYM_W-1:0]                 srt_wdata;
    logic                             tab_we;
    logic                             fi_we;
    logic [LEN_W-1:0]                 fi_addr;
    logic [CNT_W-1:0]                 fi_data;

    // handshake and step conditions
    logic in_acc;
    logic out_free;
    logic scan_match;
    logic scan_fit;
    logic scan_end;
    logic last_len;

    // shared compare unit for decode
    logic [CNT_W-1:0]        dec_cnt;
    logic [MAX_CODE_LEN-1:0] dec_fc;
    logic [CNT_W-1:0]        dec_fi;
    logic [MAX_CODE_LEN:0]   dec_diff;
    logic                    dec_hit;
    logic [CNT_W-1:0]        dec_pos;

    assign i_in.ready = (r_state == chd_pkg::S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_len   = (r_len == LEN_W'(MAX_CODE_LEN));

    // a stored length only matches the length under scan; zero and over-long
    // lengths never do
    assign scan_match = r_rd_vld && (r_rd_len == chd_pkg::LEN_FIELD_W'(r_len));
    // the code fits its length; once a code overflows, all later ones do too
    assign scan_fit   = !r_big && ((r_c >> r_len) == '0);
    assign scan_end   = (r_s == CNT_W'(NUM_SYMBOLS)) && !r_rd_vld;

    // window prefix r_v against the code range of length r_len
    always_comb begin
        dec_cnt  = r_count[r_len];
        dec_fc   = r_first_code[r_len];
        dec_fi   = r_first_idx[r_len];
        dec_diff = {1'b0, r_v} - {1'b0, dec_fc};
        dec_hit  = (dec_cnt != '0) && !dec_diff[MAX_CODE_LEN]
                   && (CMP_W'(dec_diff[MAX_CODE_LEN-1:0]) < CMP_W'(dec_cnt));
        dec_pos  = dec_fi + CNT_W'(dec_diff[MAX_CODE_LEN-1:0]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chd_pkg::S_CLEAR: begin
                if (r_s == CNT_W'(NUM_SYMBOLS - 1)) n_state = chd_pkg::S_IDLE;
            end
            chd_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        chd_pkg::KIND_BUILD:  n_state = chd_pkg::S_BSCAN;
                        chd_pkg::KIND_DECODE: n_state = chd_pkg::S_DSTEP;
                        default:              n_state = chd_pkg::S_IDLE;
                    endcase
                end
            end
            chd_pkg::S_BSCAN: begin
                if (scan_end && last_len) n_state = chd_pkg::S_IDLE;
            end
            chd_pkg::S_DSTEP: begin
                if (dec_hit)       n_state = chd_pkg::S_DREAD;
                else if (last_len) n_state = chd_pkg::S_DDONE;
            end
            chd_pkg::S_DREAD: n_state = chd_pkg::S_DDONE;
            chd_pkg::S_DDONE: begin
                if (out_free) n_state = chd_pkg::S_IDLE;
            end
            default: n_state = chd_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_len       = r_len;
        n_s         = r_s;
        n_rd_vld    = r_rd_vld;
        n_rd_sym    = r_rd_sym;
        n_c         = r_c;
        n_big       = r_big;
        n_n         = r_n;
        n_first     = r_first;
        n_pos       = r_pos;
        n_v         = r_v;
        n_win       = r_win;
        n_idx       = r_idx;
        n_miss      = r_miss;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_sym   = r_out_sym;
        n_out_bits  = r_out_bits;
        n_out_end   = r_out_end;
        n_out_miss  = r_out_miss;
        len_we      = 1'b0;
        len_waddr   = r_s[SYM_W-1:0];
        len_wdata   = '0;
        len_re      = 1'b0;
        len_raddr   = r_s[SYM_W-1:0];
        srt_we      = 1'b0;
        srt_waddr   = r_pos[SYM_W-1:0];
        srt_wdata   = r_rd_sym;
        tab_we      = 1'b0;
        fi_we       = 1'b0;
        fi_addr     = LEN_W'(1);
        fi_data     = '0;

        case (r_state)
            // zero the length memory, one entry a cycle
            chd_pkg::S_CLEAR: begin
                len_we = 1'b1;
                n_s    = r_s + 1'b1;
            end
            chd_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        chd_pkg::KIND_LOAD: begin
                            len_we    = 32'(i_in.symbol_index) < 32'(NUM_SYMBOLS);
                            len_waddr = SYM_W'(i_in.symbol_index);
                            len_wdata = i_in.code_length;
                        end
                        chd_pkg::KIND_BUILD: begin
                            n_len    = LEN_W'(1);
                            n_c      = '0;
                            n_big    = 1'b0;
                            n_pos    = '0;
                            n_n      = '0;
                            n_s      = '0;
                            n_rd_vld = 1'b0;
                            fi_we    = 1'b1;
                        end
                        chd_pkg::KIND_DECODE: begin
                            n_len  = LEN_W'(1);
                            n_v    = MAX_CODE_LEN'(i_in.bit_window[chd_pkg::WIN_W-1]);
                            n_win  = {i_in.bit_window[chd_pkg::WIN_W-2:0], 1'b0};
                            n_miss = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            // one pass over the length memory per code length
            chd_pkg::S_BSCAN: begin
                if (r_s != CNT_W'(NUM_SYMBOLS)) begin
                    len_re   = 1'b1;
                    n_s      = r_s + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_sym = r_s[SYM_W-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (scan_match) begin
                    srt_we = 1'b1;
                    n_pos  = r_pos + 1'b1;
                    if (scan_fit) begin
                        n_c = r_c + 1'b1;
                        n_n = r_n + 1'b1;
                        if (r_n == '0) n_first = r_c[MAX_CODE_LEN-1:0];
                    end else begin
                        n_big = 1'b1;
                    end
                end
                if (scan_end) begin
                    tab_we = 1'b1;
                    if (!last_len) begin
                        n_len   = r_len + 1'b1;
                        n_c     = r_big ? r_c : {r_c[CODE_W-2:0], 1'b0};
                        fi_we   = 1'b1;
                        fi_addr = r_len + 1'b1;
                        fi_data = r_pos;
                        n_s     = '0;
                        n_n     = '0;
                    end
                end
            end
            // one code length per cycle, shortest first
            chd_pkg::S_DSTEP: begin
                if (dec_hit) begin
                    n_idx = dec_pos[SYM_W-1:0];
                end else if (last_len) begin
                    n_miss = 1'b1;
                end else begin
                    n_len = r_len + 1'b1;
                    n_v   = {r_v[MAX_CODE_LEN-2:0], r_win[chd_pkg::WIN_W-1]};
                    n_win = {r_win[chd_pkg::WIN_W-2:0], 1'b0};
                end
            end
            chd_pkg::S_DREAD: ;
            chd_pkg::S_DDONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_miss  = r_miss;
                    n_out_sym   = r_miss ? '0 : chd_pkg::SYM_FIELD_W'(r_sym_rd);
                    n_out_bits  = r_miss ? '0 : chd_pkg::LEN_FIELD_W'(r_len);
                    n_out_end   = !r_miss
                                  && (chd_pkg::SYM_FIELD_W'(r_sym_rd) == r_end_symbol);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= chd_pkg::S_CLEAR;
            r_s          <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_end_symbol <= chd_pkg::END_SYMBOL_RST;
        end else begin
            r_state     <= n_state;
            r_s         <= n_s;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_end_symbol <= i_cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_rd_sym   <= n_rd_sym;
        r_c        <= n_c;
        r_big      <= n_big;
        r_n        <= n_n;
        r_first    <= n_first;
        r_pos      <= n_pos;
        r_v        <= n_v;
        r_win      <= n_win;
        r_idx      <= n_idx;
        r_miss     <= n_miss;
        r_out_sym  <= n_out_sym;
        r_out_bits <= n_out_bits;
        r_out_end  <= n_out_end;
        r_out_miss <= n_out_miss;
    end

    // code length memory
    always_ff @(posedge i_clk) begin
        if (len_we) mem_len[len_waddr] <= len_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (len_re) r_rd_len <= mem_len[len_raddr];
    end

    // symbols in canonical order
    always_ff @(posedge i_clk) begin
        if (srt_we) mem_sorted[srt_waddr] <= srt_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_sym_rd <= mem_sorted[r_idx];
    end

    // per-length tables; counts start at zero so decode misses before a build
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= MAX_CODE_LEN; i++) r_count[i] <= '0;
        end else if (tab_we) begin
            r_count[r_len] <= r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) r_first_code[r_len] <= r_first;
        if (fi_we)  r_first_idx[fi_addr] <= fi_data;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.decoded_symbol = r_out_sym;
    assign o_out.bits_used      = r_out_bits;
    assign o_out.is_end         = r_out_end;
    assign o_out.no_match       = r_out_miss;

    // a matched code always points inside the sorted symbol list
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chd_pkg::S_DSTEP && dec_hit)
            |-> (32'(dec_pos) < 32'(NUM_SYMBOLS)))
        else $error("decode index beyond symbol list");

    // the running code never grows past one above its length's range
    a_code_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chd_pkg::S_BSCAN && !r_big) |-> (r_c <= (CODE_W'(1) << r_len)))
        else $error("canonical code overflowed its width");

    // sorted position never passes the symbol count during a build
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chd_pkg::S_BSCAN) |-> (32'(r_pos) <= 32'(NUM_SYMBOLS)))
        else $error("sorted position out of range");

    // a finished decode with a free output register shows its result next cycle
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chd_pkg::S_DDONE && out_free) |=> (o_out.valid
            && r_state == chd_pkg::S_IDLE))
        else $error("decode result not presented");

    // a miss carries no symbol and no length
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_match)
            |-> (o_out.bits_used == '0 && o_out.decoded_symbol == '0 && !o_out.is_end))
        else $error("miss result carries payload");

endmodule

>>> bench/chd_scoreboard.sv
// ----------------------------------------------------------------------------
// chd_scoreboard
// watches the item and result channels, predicts every decode and compares
// ----------------------------------------------------------------------------
// the code book is kept here as a second copy. it follows length loads,
// rebuilds on every build item and looks up each decode window. expected
// results queue up in order and each accepted result is checked against the
// oldest one, field by field.
// ----------------------------------------------------------------------------
module chd_scoreboard (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [chd_pkg::SYM_FIELD_W-1:0]  i_cfg_wr_data,
    chd_in_if                                i_in,
    chd_out_if                               i_out,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_decodes,
    output int                               o_misses,
    output int                               o_end_hits
);
    import chd_pkg::*;

    localparam int NSYM   = NUM_SYMBOLS_DEF;
    localparam int MAXLEN = MAX_CODE_LEN_DEF;

    typedef struct packed {
        logic [SYM_FIELD_W-1:0] symbol;
        logic [LEN_FIELD_W-1:0] used;
        logic                   is_end;
        logic                   miss;
    } t_decode_result;

    logic [LEN_FIELD_W-1:0] code_len_mem [0:NSYM-1];
    logic [SYM_FIELD_W-1:0] canon_order  [0:NSYM-1];
    logic [WIN_W-1:0]       first_code   [0:MAXLEN];
    logic [SYM_FIELD_W-1:0] code_count   [0:MAXLEN];
    logic [SYM_FIELD_W-1:0] first_pos    [0:MAXLEN];
    logic [SYM_FIELD_W-1:0] end_sym;

    t_decode_result expected_decodes [$];

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        o_decodes  = 0;
        o_misses   = 0;
        o_end_hits = 0;
    end

    function automatic void clear_code_book();
        int i;
        for (i = 0; i < NSYM; i++) begin
            code_len_mem[i] = '0;
            canon_order[i]  = '0;
        end
        for (i = 0; i <= MAXLEN; i++) begin
            first_code[i] = '0;
            code_count[i] = '0;
            first_pos[i]  = '0;
        end
        end_sym = END_SYMBOL_RST;
    endfunction

    // canonical assignment at full precision, codes that overflow their
    // length are left out of the count
    function automatic void rebuild_code_book();
        logic [63:0] code, first, limit, room, fit;
        bit          any;
        int          prev_len, pos, n, len, s;
        code     = '0;
        any      = 1'b0;
        prev_len = 0;
        pos      = 0;
        for (len = 0; len <= MAXLEN; len++) begin
            first_code[len] = '0;
            code_count[len] = '0;
            first_pos[len]  = '0;
        end
        for (len = 1; len <= MAXLEN; len++) begin
            n     = 0;
            first = '0;
            limit = 64'd1 << len;
            first_pos[len] = SYM_FIELD_W'(pos);
            for (s = 0; s < NSYM; s++) begin
                if (code_len_mem[s] == LEN_FIELD_W'(len)) begin
                    if (any)
                        code = (code + 64'd1) << (len - prev_len);
                    else
                        code = '0;
                    any      = 1'b1;
                    prev_len = len;
                    if (n == 0)
                        first = code;
                    n++;
                    if (pos < NSYM)
                        canon_order[pos] = SYM_FIELD_W'(s);
                    pos++;
                end
            end
            if (n != 0 && first < limit) begin
                room = limit - first;
                fit  = (64'(n) < room) ? 64'(n) : room;
                first_code[len] = first[WIN_W-1:0];
                code_count[len] = fit[SYM_FIELD_W-1:0];
            end
        end
    endfunction

    // shortest fitting code wins
    function automatic t_decode_result lookup_window(input logic [WIN_W-1:0] window);
        t_decode_result res;
        logic [63:0]    v, f, p;
        int             len;
        res      = '0;
        res.miss = 1'b1;
        for (len = 1; len <= MAXLEN; len++) begin
            v = 64'(window) >> (WIN_W - len);
            f = 64'(first_code[len]);
            if (code_count[len] != 0 && v >= f && (v - f) < 64'(code_count[len])) begin
                p = 64'(first_pos[len]) + (v - f);
                res.symbol = (p < NSYM) ? canon_order[p[SYM_FIELD_W-1:0]] : '0;
                res.used   = LEN_FIELD_W'(len);
                res.is_end = (res.symbol == end_sym);
                res.miss   = 1'b0;
                return res;
            end
        end
        return res;
    endfunction

    function automatic void check_result();
        t_decode_result want;
        if (expected_decodes.size() == 0) begin
            $display("%0t  unexpected result: symbol %0d bits %0d end %0b miss %0b",
                     $time, i_out.decoded_symbol, i_out.bits_used, i_out.is_end,
                     i_out.no_match);
            o_errors++;
            return;
        end
        want = expected_decodes.pop_front();
        if (i_out.decoded_symbol !== want.symbol) begin
            $display("%0t  decoded_symbol: expected %0d, got %0d",
                     $time, want.symbol, i_out.decoded_symbol);
            o_errors++;
        end
        if (i_out.bits_used !== want.used) begin
            $display("%0t  bits_used: expected %0d, got %0d",
                     $time, want.used, i_out.bits_used);
            o_errors++;
        end
        if (i_out.is_end !== want.is_end) begin
            $display("%0t  is_end: expected %0b, got %0b",
                     $time, want.is_end, i_out.is_end);
            o_errors++;
        end
        if (i_out.no_match !== want.miss) begin
            $display("%0t  no_match: expected %0b, got %0b",
                     $time, want.miss, i_out.no_match);
            o_errors++;
        end
    endfunction

    function automatic void apply_item();
        t_decode_result want;
        case (i_in.kind)
            KIND_LOAD: begin
                if (i_in.symbol_index < NSYM)
                    code_len_mem[i_in.symbol_index] = i_in.code_length;
            end
            KIND_BUILD: rebuild_code_book();
            KIND_DECODE: begin
                want = lookup_window(i_in.bit_window);
                expected_decodes.push_back(want);
                o_decodes++;
                if (want.miss)
                    o_misses++;
                if (want.is_end)
                    o_end_hits++;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_code_book();
            expected_decodes.delete();
        end else begin
            // results always stem from earlier items, so compare first
            if (i_out.valid && i_out.ready)
                check_result();
            if (i_cfg_wr_en)
                end_sym = i_cfg_wr_data;
            if (i_in.valid && i_in.ready)
                apply_item();
        end
        o_pending = expected_decodes.size();
    end

endmodule

>>> bench/canonical_huffman_decoder_test.sv
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_test
// stimulus and verdict for the canonical huffman decoder
// ----------------------------------------------------------------------------
// a directed opening walks through the corner cases of loading, building and
// decoding. then five phases follow, each setting an end symbol and an
// idling pattern, loading random code books (mostly complete prefix
// trees, some broken ones) and decoding windows shaped to reach long codes.
// checking lives in chd_scoreboard.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder_test;
    import chd_pkg::*;

    localparam int NSYM         = NUM_SYMBOLS_DEF;
    localparam int MAXLEN       = MAX_CODE_LEN_DEF;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    // a build is the slowest thing the block does, so it bounds the drain
    localparam int DRAIN_CYCLES = MAXLEN * (NSYM + 2) + 64;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 185;
    localparam int NUM_PHASES   = 5;

    // the one kind the block drops
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [SYM_FIELD_W-1:0] cfg_wr_data = '0;

    chd_in_if  item_ch ();
    chd_out_if result_ch ();

    int errors, pending, decodes, misses, end_hits;

    canonical_huffman_decoder DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (item_ch),
        .o_out         (result_ch)
    );

    chd_scoreboard u_scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (item_ch),
        .i_out         (result_ch),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_decodes     (decodes),
        .o_misses      (misses),
        .o_end_hits    (end_hits)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // run-away guard
    int cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // idling knobs, percent per cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // long hold-off requests: the stimulus bumps holds_asked, the receiver
    // process serves them one at a time
    int holds_asked = 0;
    int holds_done = 0;
    int held;

    // result side: random back-pressure, or a long hold while the sender
    // keeps offering decodes so the block fills up and drops its ready
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    result_ch.ready = 1'b0;
                    @(negedge clk);
                end
            end
            result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // lengths as the block holds them, to clear stale entries between books
    logic [LEN_FIELD_W-1:0] loaded_len [0:NSYM-1];
    // lengths wanted for the next book
    logic [LEN_FIELD_W-1:0] book_len [0:NSYM-1];

    int items_sent = 0;
    int phase_items = 0;
    int builds = 0;
    int cfg_writes = 0;

    // one item on the input channel; returns at the falling edge after the
    // handshake with valid still high; the next offer replaces it or lowers it to idle, a quiet call lowers it
    task automatic offer_item(input logic [KIND_W-1:0]      kind,
                              input logic [SYM_FIELD_W-1:0] sym,
                              input logic [LEN_FIELD_W-1:0] len,
                              input logic [WIN_W-1:0]       window);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid        = 1'b1;
        item_ch.kind         = kind;
        item_ch.symbol_index = sym;
        item_ch.code_length  = len;
        item_ch.bit_window   = window;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        phase_items++;
        if (kind == KIND_LOAD && sym < NSYM)
            loaded_len[sym] = len;
    endtask

    task automatic load_length(input int sym, input int len);
        offer_item(KIND_LOAD, SYM_FIELD_W'(sym), LEN_FIELD_W'(len), $urandom);
    endtask

    task automatic request_build();
        offer_item(KIND_BUILD, SYM_FIELD_W'($urandom), LEN_FIELD_W'($urandom), $urandom);
        builds++;
    endtask

    task automatic decode_window(input logic [WIN_W-1:0] window);
        offer_item(KIND_DECODE, SYM_FIELD_W'($urandom), LEN_FIELD_W'($urandom), window);
    endtask

    task automatic offer_unused_kind();
        offer_item(KIND_UNUSED, SYM_FIELD_W'($urandom), LEN_FIELD_W'($urandom), $urandom);
    endtask

    // drop valid, let every expected result come back, then give the block
    // time to finish a trailing load or build
    task automatic wait_until_idle();
        item_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_end_symbol(input logic [SYM_FIELD_W-1:0] value);
        wait_until_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cfg_writes++;
    endtask

    // windows: plain random, runs of ones then a zero (canonical long codes
    // sit at the top of the code space), runs of zeros, and the two extremes
    function automatic logic [WIN_W-1:0] shaped_window();
        int               pick, run;
        logic [WIN_W-1:0] ones, tail;
        pick = $urandom_range(99);
        if (pick < 30)
            return $urandom;
        if (pick < 70) begin
            run  = $urandom_range(WIN_W);
            ones = ~({WIN_W{1'b1}} >> run);
            tail = (run >= WIN_W - 1) ? '0 : ($urandom >> (run + 1));
            return ones | tail;
        end
        if (pick < 85)
            return $urandom >> $urandom_range(WIN_W, 1);
        if (pick < 92)
            return {WIN_W{1'b1}};
        return '0;
    endfunction

    // next book into book_len: a complete prefix tree grown by splitting
    // leaves (deepest split now and then, to get long codes), or a broken
    // book with random, over-long and oversubscribed lengths
    task automatic plan_book(input int nsyms, input bit complete_tree);
        int order [0:NSYM-1];
        int leaf_depth [$];
        int i, j, tmp, pick, deepest, shallowest, r;
        for (i = 0; i < NSYM; i++) begin
            book_len[i] = '0;
            order[i]    = i;
        end
        for (i = NSYM - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        if (complete_tree) begin
            leaf_depth = {1, 1};
            while (leaf_depth.size() < nsyms) begin
                deepest    = -1;
                shallowest = 0;
                for (i = 0; i < leaf_depth.size(); i++) begin
                    if (leaf_depth[i] < MAXLEN &&
                        (deepest < 0 || leaf_depth[i] > leaf_depth[deepest]))
                        deepest = i;
                    if (leaf_depth[i] < leaf_depth[shallowest])
                        shallowest = i;
                end
                pick = ($urandom_range(3) == 0) ? deepest
                                                : $urandom_range(leaf_depth.size() - 1);
                if (leaf_depth[pick] >= MAXLEN)
                    pick = shallowest;
                leaf_depth[pick] = leaf_depth[pick] + 1;
                leaf_depth.push_back(leaf_depth[pick]);
            end
            for (i = 0; i < nsyms; i++)
                book_len[order[i]] = LEN_FIELD_W'(leaf_depth[i]);
        end else begin
            for (i = 0; i < nsyms; i++) begin
                r = $urandom_range(99);
                if (r < 8)
                    book_len[order[i]] = LEN_FIELD_W'($urandom_range(63, MAXLEN + 1));
                else if (r < 13)
                    book_len[order[i]] = '0;
                else
                    book_len[order[i]] = LEN_FIELD_W'($urandom_range(MAXLEN, 1));
            end
        end
    endtask

    // a symbol that the planned book actually codes, for the end marker
    function automatic logic [SYM_FIELD_W-1:0] coded_book_symbol();
        int coded [$];
        int s;
        for (s = 0; s < NSYM; s++)
            if (book_len[s] != 0 && book_len[s] <= MAXLEN)
                coded.push_back(s);
        if (coded.size() == 0)
            return END_SYMBOL_RST;
        return SYM_FIELD_W'(coded[$urandom_range(coded.size() - 1)]);
    endfunction

    // only differences are loaded; stale lengths get cleared the same way.
    // now and then a load beyond the symbol range slips in
    task automatic load_book();
        int s;
        for (s = 0; s < NSYM; s++) begin
            if (loaded_len[s] != book_len[s])
                load_length(s, book_len[s]);
            if ($urandom_range(99) < 3)
                load_length($urandom_range(511, NSYM), $urandom_range(63));
        end
    endtask

    // decodes on the current book with a little noise mixed in: the dropped
    // kind, out-of-range loads and loads that only count after the next build
    task automatic run_decodes(input int count);
        int n, r;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 3)
                offer_unused_kind();
            else if (r < 5)
                load_length($urandom_range(511, NSYM), $urandom_range(63));
            else if (r < 8)
                load_length($urandom_range(NSYM - 1), $urandom_range(63));
            else
                decode_window(shaped_window());
        end
    endtask

    // per phase: sender idle, receiver stall, end symbol value and coded flag
    // (a set coded flag picks a coded symbol of the first book, else the listed end value)
    int                     phase_idle  [0:NUM_PHASES-1] = '{0, 58, 0, 9, 0};
    int                     phase_stall [0:NUM_PHASES-1] = '{0, 0, 58, 9, 0};
    logic [SYM_FIELD_W-1:0] phase_end   [0:NUM_PHASES-1] = '{0, 9'h1FF, 9'h000, 0, 9'd256};
    bit                     phase_coded [0:NUM_PHASES-1] = '{1, 0, 0, 1, 0};

    int  phase, nsyms, s;
    bit  first_book;

    initial begin
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_LOAD;
        item_ch.symbol_index = '0;
        item_ch.code_length  = '0;
        item_ch.bit_window   = '0;
        for (s = 0; s < NSYM; s++)
            loaded_len[s] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // ---- directed opening, end symbol still at its reset value ----
        // decode before any build: nothing is coded yet
        decode_window('0);
        // a sparse book: 0 -> "0", 256 -> "10", 5 -> "11" + 30 zeros;
        // two indexes past the symbol range and two over-long lengths that
        // build must treat as unused
        load_length(0, 1);
        load_length(256, 2);
        load_length(5, MAXLEN);
        load_length(300, 7);
        load_length(511, 63);
        load_length(7, 40);
        load_length(1, 33);
        request_build();
        decode_window(32'h0000_0000);
        decode_window(32'h8000_0000);
        decode_window(32'hC000_0000);
        decode_window(32'hC000_0001);
        decode_window(32'hFFFF_FFFF);
        offer_unused_kind();
        // a load after the build must not disturb decoding until rebuilt
        load_length(0, 0);
        decode_window(32'h7FFF_FFFF);
        // oversubscribe: two one-bit codes take the whole space, the longer
        // codes no longer fit in their own lengths
        load_length(2, 1);
        load_length(3, 1);
        request_build();
        decode_window(32'h0000_0000);
        decode_window(32'h8000_0000);
        decode_window(32'hFFFF_FFFF);

        // ---- random phases ----
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            phase_items = 0;
            first_book  = 1'b1;
            while (phase_items < PHASE_ITEMS) begin
                // the last phase opens with a book over every symbol
                if (phase == NUM_PHASES - 1 && first_book)
                    nsyms = NSYM;
                else if ($urandom_range(99) < 85)
                    nsyms = $urandom_range(24, 2);
                else
                    nsyms = $urandom_range(120, 25);
                plan_book(nsyms, $urandom_range(99) < 80);
                if (first_book) begin
                    write_end_symbol(phase_coded[phase] ? coded_book_symbol()
                                                        : phase_end[phase]);
                    send_idle_pct  = phase_idle[phase];
                    recv_stall_pct = phase_stall[phase];
                end
                load_book();
                request_build();
                if (phase == 0 && first_book) begin
                    // once the build is through, hold the result side off
                    // and keep the decodes coming
                    decode_window(shaped_window());
                    holds_asked++;
                end
                run_decodes($urandom_range(60, 30));
                first_book = 1'b0;
            end
        end

        // ---- wind down ----
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_until_idle();

        $display("covered %0d items over %0d builds and %0d end symbol settings",
                 items_sent, builds, cfg_writes);
        $display("checked %0d decodes: %0d without a match, %0d on the end symbol",
                 decodes, misses, end_hits);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
